[rtl/bas_pkg.sv]
// Shared types, codes and helpers for the bus address slot allocator
package bas_pkg;

  // address space of the seven-bit bus
  localparam int ADDR_W        = 7;
  localparam int ADDR_SPACE    = 1 << ADDR_W;
  localparam int ADDRESS_LIMIT = 127;
  localparam int SUM_W         = ADDR_W + 1;

  // slot table defaults and fixed port widths
  localparam int SLOT_COUNT_DEF = 32;
  localparam int SLOT_IN_W      = 5;
  localparam int ACT_W          = 3;
  localparam int STATUS_W       = 2;
  localparam int EVENT_W        = 2;
  localparam int COUNT_OUT_W    = 6;

  // reset values
  localparam logic [ADDR_W-1:0] CAND_RESET   = 7'd7;
  localparam logic [ADDR_W-1:0] STRIDE_RESET = 7'd11;
  localparam logic [ADDR_W-1:0] TRY_LAST     = ADDR_W'(ADDRESS_LIMIT - 1);

  // action codes
  localparam logic [ACT_W-1:0] ACT_OFFER  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ENABLE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

  // host event codes
  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_NEW     = 2'd1;
  localparam logic [EVENT_W-1:0] EV_MISSING = 2'd2;

  // datapath operation for the current cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_OFFER,
    OP_ADD,
    OP_SLOT_RD,
    OP_SLOT_OP,
    OP_CLEAR,
    OP_NONE
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    op_t  op;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic offer_stop;
    logic add_stop;
  } dp_stat_t;

  // one step of the candidate walk, wrapping above the address limit
  function automatic logic [ADDR_W-1:0] step_candidate(input logic [ADDR_W-1:0] cand,
                                                       input logic [ADDR_W-1:0] stride);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, cand} + {1'b0, stride};
    if (sum > SUM_W'(ADDRESS_LIMIT)) begin
      sum = sum - SUM_W'(ADDRESS_LIMIT);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[rtl/bus_address_slot_allocator.sv]
// Top level of the bus address slot allocator
// An item is taken when start is high and busy is low; its result shows on the out_ ports
// for one cycle with out_strobe, one cycle after the item's last working cycle, and the
// receiver must take it then. A new item may start in the strobe cycle. Cycles from accept
// to strobe: offer 1 + k, where k is the number of candidate addresses probed (1 to 127,
// one used-map lookup per cycle); add 1 + s, where s is the number of slots scanned to the
// first empty one (1 to SLOT_COUNT, one valid bit per cycle); remove, lookup and enable 3
// (slot store read, then update); clear and unused actions 2. Clear is a single cycle on
// valid bits, with no sweep. The stride register may be written only while busy is low.
module bus_address_slot_allocator #(
  parameter int SLOT_COUNT = bas_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bas_pkg::ACT_W-1:0]         in_action,
  input  logic [bas_pkg::ADDR_W-1:0]        in_bus_address,
  input  logic [bas_pkg::SLOT_IN_W-1:0]     in_slot_index,
  input  logic                              cfg_write_en,
  input  logic [bas_pkg::ADDR_W-1:0]        cfg_write_data,
  output logic                              out_strobe,
  output logic [bas_pkg::STATUS_W-1:0]      out_status,
  output logic [bas_pkg::ADDR_W-1:0]        out_result_address,
  output logic [bas_pkg::SLOT_IN_W-1:0]     out_result_slot,
  output logic                              out_irq_enabled,
  output logic [bas_pkg::EVENT_W-1:0]       out_host_event,
  output logic [bas_pkg::COUNT_OUT_W-1:0]   out_device_count
);

  bas_pkg::ctl_cmd_t cmd;
  bas_pkg::dp_stat_t stat;

  // sequencer
  bas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // tables and result registers
  bas_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_bus_address     (in_bus_address),
    .in_slot_index      (in_slot_index),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_result_slot    (out_result_slot),
    .out_irq_enabled    (out_irq_enabled),
    .out_host_event     (out_host_event),
    .out_device_count   (out_device_count)
  );

endmodule

[rtl/bas_ctrl.sv]
// Sequencing state machine for the bus address slot allocator
module bas_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bas_pkg::ACT_W-1:0]   in_action,
  input  bas_pkg::dp_stat_t           stat,
  output bas_pkg::ctl_cmd_t           cmd,
  output logic                        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFER,
    S_ADD,
    S_SLOT_RD,
    S_SLOT_OP,
    S_CLEAR,
    S_NONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // next state and command to the datapath
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.op     = bas_pkg::OP_IDLE;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          cmd.load = 1'b1;
          case (in_action)
            bas_pkg::ACT_OFFER:  state_nxt = S_OFFER;
            bas_pkg::ACT_ADD:    state_nxt = S_ADD;
            bas_pkg::ACT_REMOVE: state_nxt = S_SLOT_RD;
            bas_pkg::ACT_LOOKUP: state_nxt = S_SLOT_RD;
            bas_pkg::ACT_ENABLE: state_nxt = S_SLOT_RD;
            bas_pkg::ACT_CLEAR:  state_nxt = S_CLEAR;
            default:             state_nxt = S_NONE;
          endcase
        end
      end
      S_OFFER: begin
        cmd.op = bas_pkg::OP_OFFER;
        if (stat.offer_stop) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ADD: begin
        cmd.op = bas_pkg::OP_ADD;
        if (stat.add_stop) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SLOT_RD: begin
        cmd.op    = bas_pkg::OP_SLOT_RD;
        state_nxt = S_SLOT_OP;
      end
      S_SLOT_OP: begin
        cmd.op     = bas_pkg::OP_SLOT_OP;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLEAR: begin
        cmd.op     = bas_pkg::OP_CLEAR;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_NONE: begin
        cmd.op     = bas_pkg::OP_NONE;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[rtl/bas_datapath.sv]
// Address map, slot table, candidate walk and result registers
module bas_datapath #(
  parameter int SLOT_COUNT = bas_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bas_pkg::ctl_cmd_t                 cmd,
  output bas_pkg::dp_stat_t                 stat,
  input  logic [bas_pkg::ACT_W-1:0]         in_action,
  input  logic [bas_pkg::ADDR_W-1:0]        in_bus_address,
  input  logic [bas_pkg::SLOT_IN_W-1:0]     in_slot_index,
  input  logic                              cfg_write_en,
  input  logic [bas_pkg::ADDR_W-1:0]        cfg_write_data,
  output logic                              out_strobe,
  output logic [bas_pkg::STATUS_W-1:0]      out_status,
  output logic [bas_pkg::ADDR_W-1:0]        out_result_address,
  output logic [bas_pkg::SLOT_IN_W-1:0]     out_result_slot,
  output logic                              out_irq_enabled,
  output logic [bas_pkg::EVENT_W-1:0]       out_host_event,
  output logic [bas_pkg::COUNT_OUT_W-1:0]   out_device_count
);

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int WORD_W = bas_pkg::ADDR_W + 1;
  localparam logic [SIDX_W-1:0] SCAN_LAST = SIDX_W'(SLOT_COUNT - 1);

  // latched item fields
  logic [bas_pkg::ACT_W-1:0]     action_r;
  logic [bas_pkg::ADDR_W-1:0]    addr_r;
  logic [bas_pkg::SLOT_IN_W-1:0] slot_r;

  // control state: map, slot valid bits, pointer, count, counters
  logic [bas_pkg::ADDR_SPACE-1:0] used_r, used_nxt;
  logic [SLOT_COUNT-1:0]          occ_r, occ_nxt;
  logic [bas_pkg::ADDR_W-1:0]     cand_r, cand_nxt;
  logic [bas_pkg::ADDR_W-1:0]     stride_r;
  logic [bas_pkg::ADDR_W-1:0]     try_r, try_nxt;
  logic [SIDX_W-1:0]              scan_r, scan_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;

  // slot store: {irq enable, address}, valid only where occ_r is set
  logic [WORD_W-1:0] slot_mem [SLOT_COUNT];
  logic [WORD_W-1:0] rd_r;
  logic              mem_we;
  logic [SIDX_W-1:0] mem_wa;
  logic [WORD_W-1:0] mem_wd;

  // result staging
  logic [bas_pkg::STATUS_W-1:0]  res_status;
  logic [bas_pkg::ADDR_W-1:0]    res_addr;
  logic [bas_pkg::SLOT_IN_W-1:0] res_slot;
  logic                          res_irq;
  logic [bas_pkg::EVENT_W-1:0]   res_event;

  logic                          out_valid_r;
  logic [bas_pkg::STATUS_W-1:0]  out_status_r;
  logic [bas_pkg::ADDR_W-1:0]    out_addr_r;
  logic [bas_pkg::SLOT_IN_W-1:0] out_slot_r;
  logic                          out_irq_r;
  logic [bas_pkg::EVENT_W-1:0]   out_event_r;
  logic [bas_pkg::COUNT_OUT_W-1:0] out_count_r;

  logic                       cand_free;
  logic [SIDX_W-1:0]          slot_idx;
  logic                       slot_bad;
  logic [bas_pkg::ADDR_W-1:0] rd_addr;
  logic                       rd_irq;

  assign cand_free = !used_r[cand_r];
  assign slot_idx  = SIDX_W'(slot_r);
  assign slot_bad  = (int'(slot_r) >= SLOT_COUNT);
  assign rd_addr   = rd_r[bas_pkg::ADDR_W-1:0];
  assign rd_irq    = rd_r[bas_pkg::ADDR_W];

  // stop conditions for the two walking operations
  assign stat.offer_stop = cand_free || (try_r == bas_pkg::TRY_LAST);
  assign stat.add_stop   = (addr_r == '0) || !occ_r[scan_r] || (scan_r == SCAN_LAST);

  // per-operation next state and result
  always_comb begin
    used_nxt   = used_r;
    occ_nxt    = occ_r;
    cand_nxt   = cand_r;
    try_nxt    = try_r;
    scan_nxt   = scan_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    mem_wa     = scan_r;
    mem_wd     = '0;
    res_status = bas_pkg::ST_OK;
    res_addr   = '0;
    res_slot   = '0;
    res_irq    = 1'b0;
    res_event  = bas_pkg::EV_NONE;
    if (cmd.load) begin
      try_nxt  = '0;
      scan_nxt = '0;
    end
    case (cmd.op)
      bas_pkg::OP_OFFER: begin
        if (cand_free) begin
          res_addr = cand_r;
        end else begin
          cand_nxt   = bas_pkg::step_candidate(cand_r, stride_r);
          try_nxt    = try_r + 1'b1;
          res_status = bas_pkg::ST_FULL;
        end
      end
      bas_pkg::OP_ADD: begin
        if (addr_r == '0) begin
          res_status = bas_pkg::ST_INVALID;
        end else if (!occ_r[scan_r]) begin
          mem_we           = 1'b1;
          mem_wa           = scan_r;
          mem_wd           = {1'b0, addr_r};
          occ_nxt[scan_r]  = 1'b1;
          used_nxt[addr_r] = 1'b1;
          count_nxt        = count_r + 1'b1;
          res_slot         = bas_pkg::SLOT_IN_W'(scan_r);
          res_event        = bas_pkg::EV_NEW;
        end else begin
          res_status = bas_pkg::ST_FULL;
          scan_nxt   = scan_r + 1'b1;
        end
      end
      bas_pkg::OP_SLOT_OP: begin
        res_slot = slot_r;
        if (slot_bad) begin
          res_status = bas_pkg::ST_INVALID;
        end else if (!occ_r[slot_idx]) begin
          res_status = bas_pkg::ST_NOT_FOUND;
        end else begin
          case (action_r)
            bas_pkg::ACT_REMOVE: begin
              used_nxt[rd_addr] = 1'b0;
              occ_nxt[slot_idx] = 1'b0;
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
              res_event = bas_pkg::EV_MISSING;
            end
            bas_pkg::ACT_LOOKUP: begin
              res_addr = rd_addr;
              res_irq  = rd_irq;
            end
            bas_pkg::ACT_ENABLE: begin
              mem_we  = 1'b1;
              mem_wa  = slot_idx;
              mem_wd  = {1'b1, rd_addr};
              res_irq = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      bas_pkg::OP_CLEAR: begin
        used_nxt  = '0;
        occ_nxt   = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      occ_r       <= '0;
      cand_r      <= bas_pkg::CAND_RESET;
      stride_r    <= bas_pkg::STRIDE_RESET;
      try_r       <= '0;
      scan_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      occ_r       <= occ_nxt;
      cand_r      <= cand_nxt;
      try_r       <= try_nxt;
      scan_r      <= scan_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
      if (cfg_write_en) begin
        stride_r <= cfg_write_data;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      addr_r   <= in_bus_address;
      slot_r   <= in_slot_index;
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_slot_r   <= res_slot;
      out_irq_r    <= res_irq;
      out_event_r  <= res_event;
      out_count_r  <= bas_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  // slot store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (cmd.op == bas_pkg::OP_SLOT_RD) begin
      rd_r <= slot_mem[slot_idx];
    end
  end

  assign out_strobe         = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_result_slot    = out_slot_r;
  assign out_irq_enabled    = out_irq_r;
  assign out_host_event     = out_event_r;
  assign out_device_count   = out_count_r;

endmodule

[rtl/bas_checker.sv]
// Port-level checks for the bus address slot allocator, bound to the top level
module bas_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input logic [bas_pkg::STATUS_W-1:0] out_status,
  input logic [bas_pkg::EVENT_W-1:0]  out_host_event
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // busy drops exactly when the result is shown
  a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy fell without a result strobe");

  // a result is only shown while idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // no two results in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back result strobes");

  // a new-device event only comes with an ok status
  a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_host_event == bas_pkg::EV_NEW)) |-> (out_status == bas_pkg::ST_OK))
    else $error("new-device event with a failing status");

endmodule

bind bus_address_slot_allocator bas_checker u_bas_checker (.*);

[tb/tb_bus_address_slot_allocator.sv]
// Self-checking testbench for the bus address slot allocator with a built-in table predictor
`timescale 1ns / 1ps

module tb_bus_address_slot_allocator;
  import bas_pkg::*;

  localparam int SLOT_TOTAL     = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 66;
  localparam int FILL_BURST     = 34;

  // action codes the block decodes as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [ADDR_W-1:0]    bus_address;
    logic [SLOT_IN_W-1:0] slot_index;
  } bus_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ADDR_W-1:0]      result_address;
    logic [SLOT_IN_W-1:0]   result_slot;
    logic                   irq_enabled;
    logic [EVENT_W-1:0]     host_event;
    logic [COUNT_OUT_W-1:0] device_count;
  } bus_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACT_W-1:0]       in_action = '0;
  logic [ADDR_W-1:0]      in_bus_address = '0;
  logic [SLOT_IN_W-1:0]   in_slot_index = '0;
  logic                   cfg_write_en = 1'b0;
  logic [ADDR_W-1:0]      cfg_write_data = '0;
  logic                   out_strobe;
  logic [STATUS_W-1:0]    out_status;
  logic [ADDR_W-1:0]      out_result_address;
  logic [SLOT_IN_W-1:0]   out_result_slot;
  logic                   out_irq_enabled;
  logic [EVENT_W-1:0]     out_host_event;
  logic [COUNT_OUT_W-1:0] out_device_count;

  // predicted device table
  bit               used_map [ADDR_SPACE];
  logic [ADDR_W-1:0] slot_addr [SLOT_TOTAL];
  bit               slot_irq [SLOT_TOTAL];
  logic [ADDR_W-1:0] next_cand;
  logic [ADDR_W-1:0] stride;
  int               occ_count;

  bus_cmd_t   pending[$];
  bus_reply_t replies[$];
  bus_cmd_t   cur_cmd;
  bus_reply_t want;
  logic       took_item = 1'b0;
  bit         idle_en = 1'b1;
  int         gap_left = 0;
  int         quiet_cycles = 0;
  int         errors = 0;
  logic [ADDR_W-1:0] last_addr = 7'd1;

  bus_address_slot_allocator #(.SLOT_COUNT(SLOT_TOTAL)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_bus_address     (in_bus_address),
    .in_slot_index      (in_slot_index),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_result_slot    (out_result_slot),
    .out_irq_enabled    (out_irq_enabled),
    .out_host_event     (out_host_event),
    .out_device_count   (out_device_count)
  );

  always #1 clk = ~clk;

  // empty the map, the slots and the count
  function automatic void clear_table();
    for (int a = 0; a < ADDR_SPACE; a++) begin
      used_map[a] = 1'b0;
    end
    for (int s = 0; s < SLOT_TOTAL; s++) begin
      slot_addr[s] = '0;
      slot_irq[s]  = 1'b0;
    end
    occ_count = 0;
  endfunction

  // table update and reply for one item
  function automatic bus_reply_t apply_command(bus_cmd_t c);
    bus_reply_t r;
    logic [ADDR_W:0] probe;
    bit found;
    r = '0;
    found = 1'b0;
    case (c.action)
      ACT_OFFER: begin
        // walk by the stride, folding back past the top address
        r.status = ST_FULL;
        for (int i = 0; i < ADDRESS_LIMIT && !found; i++) begin
          if (!used_map[next_cand]) begin
            found = 1'b1;
            r.status = ST_OK;
            r.result_address = next_cand;
          end else begin
            probe = {1'b0, next_cand} + {1'b0, stride};
            if (probe > 8'd127) begin
              probe = probe - 8'd127;
            end
            next_cand = probe[ADDR_W-1:0];
          end
        end
      end
      ACT_ADD: begin
        if (c.bus_address == '0) begin
          r.status = ST_INVALID;
        end else begin
          // first empty slot wins
          r.status = ST_FULL;
          for (int i = 0; i < SLOT_TOTAL && !found; i++) begin
            if (slot_addr[i] == '0) begin
              found = 1'b1;
              slot_addr[i] = c.bus_address;
              slot_irq[i] = 1'b0;
              used_map[c.bus_address] = 1'b1;
              occ_count++;
              r.status = ST_OK;
              r.result_slot = SLOT_IN_W'(i);
              r.irq_enabled = 1'b0;
              r.host_event = EV_NEW;
            end
          end
        end
      end
      ACT_REMOVE, ACT_LOOKUP, ACT_ENABLE: begin
        r.result_slot = c.slot_index;
        if (int'(c.slot_index) >= SLOT_TOTAL) begin
          r.status = ST_INVALID;
        end else if (slot_addr[c.slot_index] == '0) begin
          r.status = ST_NOT_FOUND;
          r.irq_enabled = slot_irq[c.slot_index];
        end else begin
          if (c.action == ACT_REMOVE) begin
            // the map bit goes even if another slot holds the same address
            used_map[slot_addr[c.slot_index]] = 1'b0;
            slot_addr[c.slot_index] = '0;
            slot_irq[c.slot_index] = 1'b0;
            if (occ_count > 0) begin
              occ_count--;
            end
            r.host_event = EV_MISSING;
          end else if (c.action == ACT_LOOKUP) begin
            r.result_address = slot_addr[c.slot_index];
          end else begin
            slot_irq[c.slot_index] = 1'b1;
          end
          r.irq_enabled = slot_irq[c.slot_index];
        end
      end
      ACT_CLEAR: begin
        clear_table();
      end
      default: begin
      end
    endcase
    r.device_count = COUNT_OUT_W'(occ_count);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      errors++;
    end
  endtask

  // check results, predict accepted items, track the stride and the watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      next_cand = CAND_RESET;
      stride = STRIDE_RESET;
      took_item <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (replies.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          want = replies.pop_front();
          check_field("status", want.status, out_status);
          check_field("result_address", want.result_address, out_result_address);
          check_field("result_slot", want.result_slot, out_result_slot);
          check_field("irq_enabled", want.irq_enabled, out_irq_enabled);
          check_field("host_event", want.host_event, out_host_event);
          check_field("device_count", want.device_count, out_device_count);
        end
      end
      if (cfg_write_en) begin
        stride = cfg_write_data;
      end
      if (start && !busy) begin
        replies.push_back(apply_command('{in_action, in_bus_address, in_slot_index}));
      end
      took_item <= start && !busy;
      if ((start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL bus_address_slot_allocator");
        $finish;
      end
    end
  end

  // item driver: hold start until taken, then maybe pause
  always @(negedge clk) begin
    if (rst_n && !(start && !took_item)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        cur_cmd = pending.pop_front();
        in_action <= cur_cmd.action;
        in_bus_address <= cur_cmd.bus_address;
        in_slot_index <= cur_cmd.slot_index;
        start <= 1'b1;
        if (idle_en && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(1, 18);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void queue_cmd(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
                                    logic [SLOT_IN_W-1:0] slot);
    pending.push_back('{act, addr, slot});
  endfunction

  // mostly adds and slot operations on low slots, some noise
  function automatic bus_cmd_t random_command();
    bus_cmd_t c;
    int pick;
    c.bus_address = ADDR_W'($urandom_range(1, 127));
    if ($urandom_range(0, 15) == 0) begin
      c.bus_address = '0;
    end else if ($urandom_range(0, 7) == 0) begin
      c.bus_address = last_addr;
    end
    last_addr = (c.bus_address == '0) ? last_addr : c.bus_address;
    c.slot_index = $urandom_range(0, 1) ? SLOT_IN_W'($urandom_range(0, 7))
                                        : SLOT_IN_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 22)      c.action = ACT_OFFER;
    else if (pick < 58) c.action = ACT_ADD;
    else if (pick < 70) c.action = ACT_REMOVE;
    else if (pick < 80) c.action = ACT_LOOKUP;
    else if (pick < 92) c.action = ACT_ENABLE;
    else if (pick < 95) c.action = ACT_CLEAR;
    else                c.action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    return c;
  endfunction

  // block until nothing is queued, in flight or outstanding
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending.size() != 0 || start || replies.size() != 0 || busy);
  endtask

  task automatic write_stride(input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    logic [ADDR_W-1:0] next_stride;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, invalid add, duplicates, irq flags, spare codes, clear
    queue_cmd(ACT_OFFER, 7'd0, 5'd0);
    queue_cmd(ACT_LOOKUP, 7'd0, 5'd0);
    queue_cmd(ACT_REMOVE, 7'd0, 5'd31);
    queue_cmd(ACT_ADD, 7'd0, 5'd0);
    queue_cmd(ACT_ADD, 7'd127, 5'd0);
    queue_cmd(ACT_ADD, 7'd7, 5'd0);
    queue_cmd(ACT_ADD, 7'd1, 5'd31);
    queue_cmd(ACT_ADD, 7'd7, 5'd0);
    queue_cmd(ACT_OFFER, 7'd127, 5'd31);
    queue_cmd(ACT_ENABLE, 7'd0, 5'd1);
    queue_cmd(ACT_LOOKUP, 7'd0, 5'd1);
    queue_cmd(ACT_ENABLE, 7'd0, 5'd1);
    queue_cmd(ACT_REMOVE, 7'd0, 5'd3);
    queue_cmd(ACT_OFFER, 7'd0, 5'd0);
    queue_cmd(ACT_LOOKUP, 7'd0, 5'd31);
    queue_cmd(ACT_ENABLE, 7'd0, 5'd20);
    queue_cmd(ACT_SPARE_LO, 7'd127, 5'd31);
    queue_cmd(ACT_SPARE_HI, 7'd85, 5'd10);
    queue_cmd(ACT_REMOVE, 7'd0, 5'd1);
    queue_cmd(ACT_ADD, 7'd100, 5'd0);
    queue_cmd(ACT_LOOKUP, 7'd0, 5'd1);
    queue_cmd(ACT_CLEAR, 7'd127, 5'd31);
    queue_cmd(ACT_LOOKUP, 7'd0, 5'd0);
    queue_cmd(ACT_OFFER, 7'd0, 5'd0);

    // random phases, each at its own stride; the last one runs without pauses
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0:       next_stride = 7'd1;
        1:       next_stride = 7'd126;
        2:       next_stride = 7'd0;
        3:       next_stride = 7'd127;
        6:       next_stride = STRIDE_RESET;
        default: next_stride = ADDR_W'($urandom_range(1, 126));
      endcase
      write_stride(next_stride);
      idle_en = (p != 7);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 24) == 0) begin
          // run of adds that fills the slot table and overflows it
          for (int k = 0; k < FILL_BURST; k++) begin
            queue_cmd(ACT_ADD, ADDR_W'($urandom_range(1, 127)),
                      SLOT_IN_W'($urandom_range(0, 31)));
          end
          n += FILL_BURST;
        end else begin
          pending.push_back(random_command());
          n++;
        end
      end
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("PASS bus_address_slot_allocator");
    end else begin
      $display("FAIL bus_address_slot_allocator");
    end
    $finish;
  end

endmodule
